/* src/rcc_pkg.sv */
// ----------------------------------------------------------------------------
// rcc_pkg: shared types and constants
// Request and result layouts, configuration register indexes and reset values
// for the Reno congestion control unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rcc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_INITIAL_CWND        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_SSTHRESH    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_CLOSE_LIMIT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_START_SEND_SEQ      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_START_RECV_SEQ      = 3'd4;

  localparam logic [15:0] RST_CWND     = 16'd1;
  localparam logic [15:0] RST_SSTHRESH = 16'd10;
  localparam logic [7:0]  RST_LIMIT    = 8'd10;

  localparam logic [7:0]  DUP_TRIGGER = 8'd3;
  localparam logic [15:0] FR_INFLATE  = 16'd3;

  localparam logic OP_TIMEOUT = 1'b0;
  localparam logic OP_SEGMENT = 1'b1;

  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 136;

  typedef struct packed {
    logic        operation;
    logic [31:0] ack_number;
    logic [31:0] seq_number;
    logic [15:0] payload_length;
    logic        fin_flag;
    logic        buffer_has_room;
  } item_t;

  typedef struct packed {
    logic [15:0] congestion_window;
    logic [15:0] slow_start_threshold;
    logic [31:0] base_seq;
    logic [31:0] acked_bytes;
    logic        retransmit;
    logic        accept_payload;
    logic [31:0] next_expected_seq;
    logic        close_link;
  } result_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;
  } cfg_wr_t;

endpackage

`default_nettype wire

/* src/rcc_in_reg.sv */
// ----------------------------------------------------------------------------
// rcc_in_reg: request register
// Holds one accepted request until the update stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rcc_pkg::item_t in_item,
  input  wire logic          out_free,
  output logic               advance,
  output rcc_pkg::item_t     item
);

  logic           vld_r;
  logic           vld_nxt;
  rcc_pkg::item_t item_r;

  assign advance  = vld_r && out_free;
  assign in_ready = !vld_r || advance;
  assign item     = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

/* src/rcc_core.sv */
// ----------------------------------------------------------------------------
// rcc_core: connection state and update logic
// Holds window, threshold, counters and sequence state; computes the state
// after one request and the matching result.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rcc_pkg::cfg_wr_t cfg,
  input  wire logic             advance,
  input  wire rcc_pkg::item_t   item,
  output rcc_pkg::result_t      result
);

  logic [15:0] cwnd_r, cwnd_nxt;
  logic [15:0] ssth_r, ssth_nxt;
  logic [7:0]  dup_r, dup_nxt;
  logic [15:0] avoid_r, avoid_nxt;
  logic [7:0]  tmo_r, tmo_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] rnext_r, rnext_nxt;
  logic        closed_r, closed_nxt;
  logic [7:0]  limit_r;

  logic [31:0] acked;
  logic        retx;
  logic        accepted;
  logic [15:0] cwnd_inc;
  logic [15:0] avoid_inc;
  logic [7:0]  dup_inc;
  logic [15:0] ssth_half;

  assign cwnd_inc  = (cwnd_r == 16'hFFFF) ? cwnd_r : cwnd_r + 16'd1;
  assign avoid_inc = (avoid_r == 16'hFFFF) ? avoid_r : avoid_r + 16'd1;
  assign dup_inc   = (dup_r == 8'hFF) ? dup_r : dup_r + 8'd1;
  assign ssth_half = {1'b0, cwnd_r[15:1]};

  always_comb begin
    cwnd_nxt   = cwnd_r;
    ssth_nxt   = ssth_r;
    dup_nxt    = dup_r;
    avoid_nxt  = avoid_r;
    tmo_nxt    = tmo_r;
    base_nxt   = base_r;
    rnext_nxt  = rnext_r;
    closed_nxt = closed_r;
    acked      = 32'd0;
    retx       = 1'b0;
    accepted   = 1'b0;
    if (!closed_r) begin
      if (item.operation == rcc_pkg::OP_TIMEOUT) begin
        tmo_nxt   = (tmo_r == 8'hFF) ? tmo_r : tmo_r + 8'd1;
        avoid_nxt = 16'd0;
        dup_nxt   = 8'd0;
        ssth_nxt  = ssth_half;
        cwnd_nxt  = 16'd1;
        if (tmo_nxt >= limit_r) begin
          closed_nxt = 1'b1;
        end
      end else begin
        tmo_nxt = 8'd0;
        if (item.fin_flag) begin
          closed_nxt = 1'b1;
        end else begin
          if (item.ack_number != base_r) begin
            if (dup_r >= rcc_pkg::DUP_TRIGGER) begin
              // leaving fast recovery: deflate to threshold
              cwnd_nxt = ssth_r;
            end else if (cwnd_r < ssth_r) begin
              cwnd_nxt = cwnd_inc;
            end else begin
              // one segment per window's worth of new ACKs
              if (avoid_inc >= cwnd_r) begin
                cwnd_nxt  = cwnd_inc;
                avoid_nxt = 16'd0;
              end else begin
                avoid_nxt = avoid_inc;
              end
            end
            dup_nxt  = 8'd0;
            acked    = item.ack_number - base_r;
            base_nxt = item.ack_number;
          end else if (item.payload_length == 16'd0) begin
            dup_nxt = dup_inc;
            if (dup_inc == rcc_pkg::DUP_TRIGGER) begin
              avoid_nxt = 16'd0;
              ssth_nxt  = ssth_half;
              cwnd_nxt  = ssth_half + rcc_pkg::FR_INFLATE;
              retx      = 1'b1;
            end else if (dup_inc > rcc_pkg::DUP_TRIGGER) begin
              retx     = 1'b1;
              cwnd_nxt = cwnd_inc;
            end
          end
          if (item.payload_length != 16'd0 && item.seq_number == rnext_r &&
              item.buffer_has_room) begin
            rnext_nxt = item.seq_number + {16'd0, item.payload_length};
            accepted  = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    result.congestion_window    = cwnd_nxt;
    result.slow_start_threshold = ssth_nxt;
    result.base_seq             = base_nxt;
    result.acked_bytes          = acked;
    result.retransmit           = retx;
    result.accept_payload       = accepted;
    result.next_expected_seq    = rnext_nxt;
    result.close_link           = closed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cwnd_r   <= rcc_pkg::RST_CWND;
      ssth_r   <= rcc_pkg::RST_SSTHRESH;
      dup_r    <= 8'd0;
      avoid_r  <= 16'd0;
      tmo_r    <= 8'd0;
      base_r   <= 32'd0;
      rnext_r  <= 32'd0;
      closed_r <= 1'b0;
      limit_r  <= rcc_pkg::RST_LIMIT;
    end else if (cfg.we) begin
      unique case (cfg.index)
        rcc_pkg::CFG_INITIAL_CWND:        cwnd_r  <= cfg.wdata[15:0];
        rcc_pkg::CFG_INITIAL_SSTHRESH:    ssth_r  <= cfg.wdata[15:0];
        rcc_pkg::CFG_TIMEOUT_CLOSE_LIMIT: limit_r <= cfg.wdata[7:0];
        rcc_pkg::CFG_START_SEND_SEQ:      base_r  <= cfg.wdata;
        rcc_pkg::CFG_START_RECV_SEQ:      rnext_r <= cfg.wdata;
        default: ;
      endcase
    end else if (advance) begin
      cwnd_r   <= cwnd_nxt;
      ssth_r   <= ssth_nxt;
      dup_r    <= dup_nxt;
      avoid_r  <= avoid_nxt;
      tmo_r    <= tmo_nxt;
      base_r   <= base_nxt;
      rnext_r  <= rnext_nxt;
      closed_r <= closed_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/rcc_out_reg.sv */
// ----------------------------------------------------------------------------
// rcc_out_reg: result register
// Holds one result until the receiver takes it; frees itself on the same
// cycle it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire rcc_pkg::result_t result,
  output logic                  out_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rcc_pkg::result_t      out_result
);

  logic             vld_r;
  logic             vld_nxt;
  rcc_pkg::result_t res_r;

  assign out_free   = !vld_r || out_ready;
  assign out_valid  = vld_r;
  assign out_result = res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (out_free) begin
      vld_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

endmodule

`default_nettype wire

/* src/reno_congestion_control_unit.sv */
// ----------------------------------------------------------------------------
// reno_congestion_control_unit: Reno congestion and ACK tracker
// Each request is a receive timeout or one checked segment; each gives one
// result with window, threshold, send base, acked bytes and receive state.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request stream. in_tuser is the operation (0 timeout, 1 segment),
//           in_tlast is the FIN flag, in_tdata the remaining fields.
//   out_* : result stream, one result per request, in request order.
//   cfg_* : register write port, taken on any edge with cfg_we high; writing
//           a start value also loads the live state. Write only while idle.
// Path: the request register holds an accepted request, then the state
//   update loads the result register, which drives out_tvalid.
// Throughput: one request per cycle while results are taken; the update is a
//   single pass of compares and increments from request to result register.
// Reset (rst_n low, synchronous): both stages empty, registers and state at
//   their defaults (window 1, threshold 10, close limit 10, sequences 0).
// Stall: a held result keeps out_tdata; one more request waits in the
//   request register, then in_tready drops until out_tready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module reno_congestion_control_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // ack_number[31:0], seq_number[63:32], payload_length[79:64],
  // buffer_has_room[80], zero[87:81]
  input  wire logic [rcc_pkg::InDataW-1:0]   in_tdata,
  input  wire logic                          in_tuser,   // operation
  input  wire logic                          in_tlast,   // fin_flag
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // congestion_window[15:0], slow_start_threshold[31:16], base_seq[63:32],
  // acked_bytes[95:64], retransmit[96], accept_payload[97],
  // next_expected_seq[129:98], close_link[130], zero[135:131]
  output logic [rcc_pkg::OutDataW-1:0]       out_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [rcc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [rcc_pkg::CfgDataW-1:0]  cfg_wdata
);

  rcc_pkg::item_t   in_item;
  rcc_pkg::item_t   item;
  rcc_pkg::result_t result;
  rcc_pkg::result_t out_result;
  rcc_pkg::cfg_wr_t cfg;
  logic             advance;
  logic             out_free;

  always_comb begin
    in_item.operation       = in_tuser;
    in_item.ack_number      = in_tdata[31:0];
    in_item.seq_number      = in_tdata[63:32];
    in_item.payload_length  = in_tdata[79:64];
    in_item.fin_flag        = in_tlast;
    in_item.buffer_has_room = in_tdata[80];
    cfg.we    = cfg_we;
    cfg.index = cfg_index;
    cfg.wdata = cfg_wdata;
  end

  rcc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .out_free (out_free),
    .advance  (advance),
    .item     (item)
  );

  rcc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  rcc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .out_free   (out_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {5'd0,
                      out_result.close_link,
                      out_result.next_expected_seq,
                      out_result.accept_payload,
                      out_result.retransmit,
                      out_result.acked_bytes,
                      out_result.base_seq,
                      out_result.slow_start_threshold,
                      out_result.congestion_window};

endmodule

`default_nettype wire
